/* design/dlrd_pkg.sv */
// ============================================================================
// dlrd_pkg
// Shared constants and types of the dictionary run-length decoder.
// ============================================================================
`default_nettype none

package dlrd_pkg;

  localparam int DICT_ENTRIES_DEF   = 16;
  localparam int RUN_FIELD_BITS_DEF = 4;
  localparam int QUEUE_DEPTH_DEF    = 2;
  localparam int LITERAL_BITS       = 8;
  localparam int BYTE_BITS          = 8;
  localparam int OUT_LIMIT          = 16;
  localparam int MAX_INDEX_BITS     = 8;

  // one classified input word on its way from front to back
  typedef struct packed {
    logic [BYTE_BITS-1:0]      data;
    logic                      hdr;   // dictionary entry, not code bits
    logic                      clr;   // new stream: drop pending code bits
    logic [MAX_INDEX_BITS-1:0] idx;   // dictionary slot for a header word
  } item_t;

  typedef struct packed {
    logic busy;
  } back_status_t;

endpackage

`default_nettype wire

/* design/dlrd_ram.sv */
// ============================================================================
// dlrd_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module dlrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/dlrd_front.sv */
// ============================================================================
// dlrd_front
// Input side: counts header words and tags each word as header or code.
// ============================================================================
`default_nettype none

module dlrd_front #(
  parameter int DICT_ENTRIES = dlrd_pkg::DICT_ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [dlrd_pkg::BYTE_BITS-1:0] in_tdata,
  input  wire logic                           in_tuser,
  output logic                                push_valid,
  input  wire logic                           push_ready,
  output dlrd_pkg::item_t                     push_item
);

  localparam int IB   = $clog2(DICT_ENTRIES);
  localparam int HC_W = $clog2(DICT_ENTRIES + 1);

  logic [HC_W-1:0] hc_r, hc_nxt, hc_eff;
  logic            is_hdr;

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;

  always_comb begin
    hc_eff = in_tuser ? '0 : hc_r;
    is_hdr = hc_eff < HC_W'(DICT_ENTRIES);

    push_item.data = in_tdata;
    push_item.hdr  = is_hdr;
    push_item.clr  = in_tuser;
    push_item.idx  = dlrd_pkg::MAX_INDEX_BITS'(hc_eff[IB-1:0]);

    hc_nxt = hc_r;
    if (in_tvalid && push_ready) begin
      hc_nxt = is_hdr ? hc_eff + HC_W'(1) : hc_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r <= '0;
    end else begin
      hc_r <= hc_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/dlrd_queue.sv */
// ============================================================================
// dlrd_queue
// Short FIFO of classified words between front and back.
// ============================================================================
`default_nettype none

module dlrd_queue #(
  parameter int DEPTH = dlrd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire dlrd_pkg::item_t push_item,
  output logic                 pop_valid,
  input  wire logic            pop,
  output dlrd_pkg::item_t      pop_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  dlrd_pkg::item_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/dlrd_back.sv */
// ============================================================================
// dlrd_back
// Decode side: loads the dictionary, parses codes and expands runs.
// ============================================================================
`default_nettype none

module dlrd_back #(
  parameter int DICT_ENTRIES   = dlrd_pkg::DICT_ENTRIES_DEF,
  parameter int RUN_FIELD_BITS = dlrd_pkg::RUN_FIELD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_valid,
  input  wire dlrd_pkg::item_t                q_item,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [dlrd_pkg::LITERAL_BITS-1:0]   out_tdata,
  output logic                                out_tlast,
  output dlrd_pkg::back_status_t              status
);

  localparam int IB       = $clog2(DICT_ENTRIES);
  localparam int LIT_LEN  = 1 + dlrd_pkg::LITERAL_BITS;
  localparam int RUN_LEN  = 1 + RUN_FIELD_BITS + IB;
  localparam int MAX_LEN  = (RUN_LEN > LIT_LEN) ? RUN_LEN : LIT_LEN;
  localparam int BUF_W    = MAX_LEN - 1 + dlrd_pkg::BYTE_BITS;
  localparam int CNT_W    = $clog2(BUF_W + 1);
  localparam int N_W      = $clog2(dlrd_pkg::OUT_LIMIT + 1);
  localparam int IDXC_W   = IB + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PARSE = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;

  logic [1:0]                        state_r, state_nxt;
  logic [BUF_W-1:0]                  buf_r, buf_nxt;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic [N_W-1:0]                    n_r, n_nxt;
  logic [RUN_FIELD_BITS-1:0]         rem_r, rem_nxt;
  logic [IB-1:0]                     idx_r, idx_nxt;
  logic                              idx_ok_r, idx_ok_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [dlrd_pkg::LITERAL_BITS-1:0] out_char_r, out_char_nxt;
  logic                              out_last_r, out_last_nxt;

  logic                              ram_we;
  logic [IB-1:0]                     ram_raddr;
  logic [dlrd_pkg::LITERAL_BITS-1:0] ram_rdata;

  logic [BUF_W-1:0]                  top_sh, code_sh, buf2;
  logic [CNT_W-1:0]                  code_len, cnt2;
  logic                              flag, have, more2, more_cur, load, at_cap, cap_next;
  logic [IB-1:0]                     cur_idx;
  logic [RUN_FIELD_BITS-1:0]         cur_run;
  logic [BUF_W+dlrd_pkg::BYTE_BITS-1:0] app;

  // a full code waits at the top of the buffer
  function automatic logic code_ready(input logic [BUF_W-1:0] b, input logic [CNT_W-1:0] c);
    logic [BUF_W-1:0] sh;
    logic [CNT_W-1:0] l;
    sh = b >> (c - CNT_W'(1));
    l  = sh[0] ? CNT_W'(LIT_LEN) : CNT_W'(RUN_LEN);
    return (c != '0) && (c >= l);
  endfunction

  dlrd_ram #(
    .WIDTH (dlrd_pkg::LITERAL_BITS),
    .DEPTH (DICT_ENTRIES)
  ) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_item.idx[IB-1:0]),
    .wdata (q_item.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    top_sh   = buf_r >> (cnt_r - CNT_W'(1));
    flag     = top_sh[0];
    code_len = flag ? CNT_W'(LIT_LEN) : CNT_W'(RUN_LEN);
    have     = (cnt_r != '0) && (cnt_r >= code_len);
    code_sh  = buf_r >> (cnt_r - code_len);
    cur_idx  = code_sh[IB-1:0];
    cur_run  = code_sh[IB +: RUN_FIELD_BITS];
    cnt2     = cnt_r - code_len;
    buf2     = buf_r & ~({BUF_W{1'b1}} << cnt2);
    more2    = code_ready(buf2, cnt2);
    more_cur = code_ready(buf_r, cnt_r);
    load     = !out_valid_r || out_tready;
    at_cap   = n_r == N_W'(dlrd_pkg::OUT_LIMIT);
    cap_next = n_r == N_W'(dlrd_pkg::OUT_LIMIT - 1);
    app      = {buf_r, q_item.data};
  end

  always_comb begin
    state_nxt     = state_r;
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    rem_nxt       = rem_r;
    idx_nxt       = idx_r;
    idx_ok_nxt    = idx_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = cur_idx;

    unique case (state_r)
      S_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          if (q_item.hdr) begin
            ram_we = 1'b1;
            if (q_item.clr) begin
              buf_nxt = '0;
              cnt_nxt = '0;
            end
          end else begin
            buf_nxt   = app[BUF_W-1:0];
            cnt_nxt   = cnt_r + CNT_W'(dlrd_pkg::BYTE_BITS);
            n_nxt     = '0;
            state_nxt = S_PARSE;
          end
        end
      end
      S_PARSE: begin
        if (!have) begin
          state_nxt = S_IDLE;
        end else if (at_cap) begin
          // result limit reached: codes are consumed and dropped
          buf_nxt = buf2;
          cnt_nxt = cnt2;
        end else if (flag) begin
          if (load) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = code_sh[dlrd_pkg::LITERAL_BITS-1:0];
            out_last_nxt  = cap_next || !more2;
            buf_nxt       = buf2;
            cnt_nxt       = cnt2;
            n_nxt         = n_r + N_W'(1);
          end
        end else begin
          // dictionary read issued now, data arrives in S_RUN
          buf_nxt    = buf2;
          cnt_nxt    = cnt2;
          rem_nxt    = cur_run;
          idx_nxt    = cur_idx;
          idx_ok_nxt = IDXC_W'(cur_idx) < IDXC_W'(DICT_ENTRIES);
          state_nxt  = S_RUN;
        end
      end
      S_RUN: begin
        ram_raddr = idx_r;
        if (load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = idx_ok_r ? ram_rdata : '0;
          out_last_nxt  = cap_next || ((rem_r == '0) && !more_cur);
          n_nxt         = n_r + N_W'(1);
          rem_nxt       = rem_r - RUN_FIELD_BITS'(1);
          if ((rem_r == '0) || cap_next) begin
            state_nxt = S_PARSE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      buf_r       <= '0;
      cnt_r       <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      buf_r       <= buf_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    idx_r      <= idx_nxt;
    idx_ok_r   <= idx_ok_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_char_r;
  assign out_tlast   = out_last_r;
  assign status.busy = state_r != S_IDLE;

endmodule

`default_nettype wire

/* design/dictionary_run_length_decoder.sv */
// ============================================================================
// dictionary_run_length_decoder
// Byte-stream decoder: header words load a dictionary, code bits expand
// into literals and dictionary runs.
// ============================================================================
// Input: one word per cycle while the queue has room (header words too).
// Code word: popped in S_IDLE, parsed in S_PARSE; a literal is registered
//   out, a run reads the dictionary RAM; no new pop until back in S_IDLE.
// Reset: control state, header count and code bit buffer cleared; the
//   dictionary holds no valid data until a header loads it; no clearing pass.
`default_nettype none

module dictionary_run_length_decoder #(
  parameter int DICT_ENTRIES   = dlrd_pkg::DICT_ENTRIES_DEF,
  parameter int RUN_FIELD_BITS = dlrd_pkg::RUN_FIELD_BITS_DEF,
  parameter int QUEUE_DEPTH    = dlrd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tuser,   // [0] stream_first
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_char
  output logic             out_tlast   // run_last
);

  logic                   push_valid, push_ready, q_valid, q_pop;
  dlrd_pkg::item_t        push_item, q_item;
  dlrd_pkg::back_status_t back_status;

  dlrd_front #(
    .DICT_ENTRIES (DICT_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  dlrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  dlrd_back #(
    .DICT_ENTRIES   (DICT_ENTRIES),
    .RUN_FIELD_BITS (RUN_FIELD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .status     (back_status)
  );

  // a new stream always starts a header load at slot zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |->
      (push_item.hdr && push_item.clr && (push_item.idx == '0)))
    else $error("stream start not tagged as header slot zero");

  // characters are only produced while a code word is being decoded
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(back_status.busy))
    else $error("output word appeared without active decode");

  // dictionary is written only from an idle decoder
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_valid && q_item.hdr) |=> !back_status.busy)
    else $error("header word started a decode");

endmodule

`default_nettype wire
